@@ rtl/led_blink_controller_core_macros.svh @@
`ifndef LED_BLINK_CONTROLLER_CORE_MACROS_SVH
`define LED_BLINK_CONTROLLER_CORE_MACROS_SVH

// check cons in the cycle after ante
`define LBC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lbc check failed");

// check cons in the same cycle as ante
`define LBC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lbc check failed");

`endif

@@ rtl/lbc_pkg.sv @@
package lbc_pkg;

    localparam int unsigned CountW = 16;
    localparam int unsigned EdgeW  = CountW + 1;

    localparam logic [CountW-1:0] FULL16     = {CountW{1'b1}};
    localparam logic              CMD_CONTROL = 1'b0;
    localparam logic              CMD_TICK    = 1'b1;

    typedef struct packed {
        logic              command;
        logic [CountW-1:0] blink_count;
        logic [CountW-1:0] half_period;
    } item_t;

    typedef struct packed {
        logic led_level;
        logic command_taken;
    } result_t;

endpackage

@@ rtl/led_blink_controller_core.sv @@
// channel | handshake            | payload
// input   | in_valid / in_ready  | command, blink_count, half_period
// output  | out_valid / out_ready | led_level, command_taken
//
// One word per cycle sustained while out_ready is high: a word waits
// in the input register, then updates the LED state and lands in the
// output register, which drives out_valid.
// Reset clears the LED state and both stage valid flags.
// A stall on the output holds the result and then the input register;
// in_ready drops only when both are full and out_ready is low.

module led_blink_controller_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      command,
    input  logic [lbc_pkg::CountW-1:0] blink_count,
    input  logic [lbc_pkg::CountW-1:0] half_period,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      led_level,
    output logic                      command_taken
);
    import lbc_pkg::*;

    logic    in_valid_reg;
    item_t   item_reg;
    logic    out_valid_reg;
    result_t result_reg;
    result_t result_next;
    logic    step;

    assign step     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg.command     <= command;
            item_reg.blink_count <= blink_count;
            item_reg.half_period <= half_period;
        end
        if (step)
        begin
            result_reg <= result_next;
        end
    end

    lbc_state u_state (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (item_reg),
        .result (result_next)
    );

    assign out_valid     = out_valid_reg;
    assign led_level     = result_reg.led_level;
    assign command_taken = result_reg.command_taken;

endmodule

@@ rtl/lbc_state.sv @@
`include "led_blink_controller_core_macros.svh"

module lbc_state (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  lbc_pkg::item_t  item,
    output lbc_pkg::result_t result
);
    import lbc_pkg::*;

    logic              led_on_reg,         led_on_next;
    logic              ticks_locked_reg,   ticks_locked_next;
    logic [CountW-1:0] prior_count_reg,    prior_count_next;
    logic [CountW-1:0] prior_period_reg,   prior_period_next;
    logic [CountW-1:0] tick_countdown_reg, tick_countdown_next;
    logic [CountW-1:0] reload_value_reg,   reload_value_next;
    logic [EdgeW-1:0]  edges_left_reg,     edges_left_next;
    logic              endless_mode_reg,   endless_mode_next;
    logic              taken;

    logic              differs;
    logic              idle;
    logic [CountW-1:0] cd_dec;
    logic              fire;

    assign differs = (item.blink_count != prior_count_reg)
                  || (item.half_period != prior_period_reg);
    assign idle    = (edges_left_reg == '0) && (tick_countdown_reg == '0);
    assign cd_dec  = (tick_countdown_reg != '0) ? tick_countdown_reg - 1'b1
                                                : tick_countdown_reg;
    assign fire    = !ticks_locked_reg && (edges_left_reg != '0) && (cd_dec == '0);

    always_comb
    begin
        led_on_next         = led_on_reg;
        ticks_locked_next   = ticks_locked_reg;
        prior_count_next    = prior_count_reg;
        prior_period_next   = prior_period_reg;
        tick_countdown_next = tick_countdown_reg;
        reload_value_next   = reload_value_reg;
        edges_left_next     = edges_left_reg;
        endless_mode_next   = endless_mode_reg;
        taken               = 1'b0;

        case (item.command)
            CMD_TICK:
            begin
                tick_countdown_next = cd_dec;
                if (fire)
                begin
                    led_on_next         = !led_on_reg;
                    tick_countdown_next = reload_value_reg;
                    if (!endless_mode_reg)
                    begin
                        edges_left_next = edges_left_reg - 1'b1;
                    end
                end
            end
            CMD_CONTROL:
            begin
                if (differs || idle)
                begin
                    taken             = 1'b1;
                    prior_count_next  = item.blink_count;
                    prior_period_next = item.half_period;
                    ticks_locked_next = 1'b1;
                    if ((item.blink_count == '0) || (item.half_period == '0))
                    begin
                        led_on_next = 1'b0;
                    end
                    else if (item.half_period == FULL16)
                    begin
                        led_on_next = 1'b1;
                    end
                    else
                    begin
                        led_on_next         = 1'b0;
                        ticks_locked_next   = 1'b0;
                        reload_value_next   = item.half_period;
                        tick_countdown_next = '0;
                        if (item.blink_count == FULL16)
                        begin
                            endless_mode_next = 1'b1;
                            edges_left_next   = {1'b0, FULL16};
                        end
                        else
                        begin
                            endless_mode_next = 1'b0;
                            edges_left_next   = {item.blink_count, 1'b0};
                        end
                    end
                end
            end
            default:
            begin
                taken = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_on_reg         <= 1'b0;
            ticks_locked_reg   <= 1'b0;
            prior_count_reg    <= '0;
            prior_period_reg   <= '0;
            tick_countdown_reg <= '0;
            reload_value_reg   <= '0;
            edges_left_reg     <= '0;
            endless_mode_reg   <= 1'b0;
        end
        else if (step)
        begin
            led_on_reg         <= led_on_next;
            ticks_locked_reg   <= ticks_locked_next;
            prior_count_reg    <= prior_count_next;
            prior_period_reg   <= prior_period_next;
            tick_countdown_reg <= tick_countdown_next;
            reload_value_reg   <= reload_value_next;
            edges_left_reg     <= edges_left_next;
            endless_mode_reg   <= endless_mode_next;
        end
    end

    assign result.led_level     = led_on_next;
    assign result.command_taken = taken;

    `LBC_ASSERT_SAME(a_taken_only_on_control, step && (item.command == CMD_TICK), !taken)
    `LBC_ASSERT_NEXT(a_locked_tick_holds_led,
        step && (item.command == CMD_TICK) && ticks_locked_reg, $stable(led_on_reg))
    `LBC_ASSERT_NEXT(a_endless_keeps_edges,
        step && (item.command == CMD_TICK) && endless_mode_reg, $stable(edges_left_reg))
    `LBC_ASSERT_SAME(a_countdown_bounded, 1'b1, tick_countdown_reg <= reload_value_reg)

endmodule
